FILE: rtl/mtcd_pkg.sv
// ----------------------------------------------------------------------------
// mtcd_pkg: shared types and constants of the crank decoder
// Action codes, register indexes, reset values, sequencer states.
// ----------------------------------------------------------------------------
package mtcd_pkg;

  localparam logic [1:0] ACT_CRANK = 2'd0;
  localparam logic [1:0] ACT_CAM   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEETH = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CEIL  = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE = 8'd3;

  localparam logic [7:0]  TEETH_RST = 8'd58;
  localparam logic [15:0] FLOOR_RST = 16'd500;
  localparam logic [15:0] CEIL_RST  = 16'd8000;

  localparam int          DIV_BITS     = 32;
  localparam logic [31:0] DEG_ROUND    = 32'd180;
  localparam logic [31:0] US_PER_MIN   = 32'd60000000;
  localparam logic [8:0]  MISSING      = 9'd2;

  // Reciprocals for the constant divisions: x / 3 for any 32-bit x, and
  // z / 45 for any 29-bit z (360 = 8 * 45).
  localparam logic [31:0] RECIP_3      = 32'hAAAA_AAAB;
  localparam int          RECIP_3_SH   = 33;
  localparam logic [31:0] RECIP_45     = 32'hB60B_60B7;
  localparam int          RECIP_45_SH  = 37;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_EDGE   = 9'b000000010,
    ST_TPDIV  = 9'b000000100,
    ST_POSDIV = 9'b000001000,
    ST_MUL    = 9'b000010000,
    ST_DEGDIV = 9'b000100000,
    ST_RPMDIV = 9'b001000000,
    ST_FINAL  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

endpackage

FILE: rtl/mtcd_in_if.sv
// ----------------------------------------------------------------------------
// mtcd_in_if: edge event channel
// Valid/ready channel that carries one action code and its capture time.
// ----------------------------------------------------------------------------
interface mtcd_in_if #(parameter int STAMP_BITS = 48);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [STAMP_BITS-1:0] stamp_us;

  modport source (output valid, output action, output stamp_us, input ready);
  modport sink   (input valid, input action, input stamp_us, output ready);
endinterface

FILE: rtl/mtcd_out_if.sv
// ----------------------------------------------------------------------------
// mtcd_out_if: decoder status channel
// Valid/ready channel that carries the decoder state after each event.
// ----------------------------------------------------------------------------
interface mtcd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tooth_position;
  logic [31:0] period_us;
  logic        gap_seen;
  logic [31:0] gap_length_us;
  logic        phase_known;
  logic        acquired;
  logic        speed_valid;
  logic [15:0] speed_rpm;
  logic [31:0] us_per_degree;
  logic        revolution_half;
  logic [7:0]  cam_tooth;
  logic        cam_flag;

  modport source (output valid, output tooth_position, output period_us, output gap_seen,
                  output gap_length_us, output phase_known, output acquired,
                  output speed_valid, output speed_rpm, output us_per_degree,
                  output revolution_half, output cam_tooth, output cam_flag, input ready);
  modport sink   (input valid, input tooth_position, input period_us, input gap_seen,
                  input gap_length_us, input phase_known, input acquired,
                  input speed_valid, input speed_rpm, input us_per_degree,
                  input revolution_half, input cam_tooth, input cam_flag, output ready);
endinterface

FILE: rtl/mtcd_div.sv
// ----------------------------------------------------------------------------
// mtcd_div: shared unsigned divider
// Restoring divider, one quotient bit per cycle; quotient and remainder are
// valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module mtcd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mtcd_pkg::DIV_BITS-1:0] dividend,
  input  logic [mtcd_pkg::DIV_BITS-1:0] divisor,
  output logic [mtcd_pkg::DIV_BITS-1:0] quotient,
  output logic [mtcd_pkg::DIV_BITS-1:0] remainder,
  output mtcd_pkg::div_stat_t           stat
);
  localparam int W  = mtcd_pkg::DIV_BITS;
  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;

  always_comb begin
    trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;
endmodule

FILE: rtl/missing_tooth_crank_decoder.sv
// ----------------------------------------------------------------------------
// missing_tooth_crank_decoder: missing-tooth trigger wheel decoder
// Tracks tooth position, gap, cam phase, time per degree and engine speed.
//
//   channel | dir | handshake       | beat
//   in_ch   | in  | valid / ready   | action, stamp_us
//   out_ch  | out | valid / ready   | decoder state after the event
//   cfg_    | in  | cfg_we          | cfg_index, cfg_wdata
//
// A cam, clear or unused event, or a crank edge with no earlier stamp or a stamp
// that does not advance, goes from the edge step straight to the output step.
// A gap edge finds the period by a reciprocal multiply and the speed by at most
// one pass through the shared divider; an ordinary edge needs one more for the
// tooth index, unless the tooth count is zero. The input is ready only in idle.
// Reset is synchronous and clears all decoder state and restores the registers.
// A result still waiting on out_ch holds the next one in its output step.
// ----------------------------------------------------------------------------
module missing_tooth_crank_decoder #(
  parameter int STAMP_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mtcd_in_if.sink                             in_ch,
  mtcd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [mtcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mtcd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  mtcd_pkg::state_t state_r, state_nxt;

  logic [7:0]  teeth_r;
  logic [15:0] floor_r, ceil_r;
  logic        phchk_r;

  logic [STAMP_BITS-1:0] prev_r, stamp_r;
  logic [1:0]  act_r;
  logic [31:0] tp_r, gapp_r, deg_r, rev_r;
  logic [7:0]  pos_r, campos_r;
  logic        gapf_r, phase_r, acq_r, valid_r, revb_r, camsg_r, camev_r;
  logic [15:0] rpm_r;
  logic        ov_r;

  logic        div_start_r;
  logic [31:0] div_a_r, div_b_r, div_q, div_rem;
  mtcd_pkg::div_stat_t div_st;

  logic [31:0] span, thresh;
  logic [8:0]  positions;
  logic        gap;

  mtcd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_a_r),
    .divisor(div_b_r), .quotient(div_q), .remainder(div_rem), .stat(div_st)
  );

  assign span      = 32'(stamp_r - prev_r);
  assign thresh    = (tp_r + {tp_r[30:0], 1'b0}) >> 1;
  assign gap       = (tp_r != '0) && (span > thresh);
  assign positions = {1'b0, teeth_r} + mtcd_pkg::MISSING;

  assign in_ch.ready = (state_r == mtcd_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtcd_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = mtcd_pkg::ST_EDGE;
      mtcd_pkg::ST_EDGE: begin
        if (act_r != mtcd_pkg::ACT_CRANK || prev_r == '0 || stamp_r <= prev_r)
          state_nxt = mtcd_pkg::ST_OUT;
        else if (gap)
          state_nxt = mtcd_pkg::ST_TPDIV;
        else if (teeth_r != '0)
          state_nxt = mtcd_pkg::ST_POSDIV;
        else
          state_nxt = mtcd_pkg::ST_MUL;
      end
      mtcd_pkg::ST_TPDIV:  state_nxt = mtcd_pkg::ST_MUL;
      mtcd_pkg::ST_POSDIV: if (div_st.done) state_nxt = mtcd_pkg::ST_MUL;
      mtcd_pkg::ST_MUL:    state_nxt = mtcd_pkg::ST_DEGDIV;
      mtcd_pkg::ST_DEGDIV: begin
        state_nxt = (tp_r != '0 && rev_r != '0) ? mtcd_pkg::ST_RPMDIV
                                                : mtcd_pkg::ST_FINAL;
      end
      mtcd_pkg::ST_RPMDIV: if (div_st.done) state_nxt = mtcd_pkg::ST_FINAL;
      mtcd_pkg::ST_FINAL:  state_nxt = mtcd_pkg::ST_OUT;
      mtcd_pkg::ST_OUT:    if (!ov_r || out_ch.ready) state_nxt = mtcd_pkg::ST_IDLE;
      default:             state_nxt = mtcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtcd_pkg::ST_IDLE;
      teeth_r     <= mtcd_pkg::TEETH_RST;
      floor_r     <= mtcd_pkg::FLOOR_RST;
      ceil_r      <= mtcd_pkg::CEIL_RST;
      phchk_r     <= 1'b1;
      prev_r      <= '0;
      tp_r        <= '0;
      pos_r       <= '0;
      gapf_r      <= 1'b0;
      gapp_r      <= '0;
      phase_r     <= 1'b0;
      acq_r       <= 1'b0;
      valid_r     <= 1'b0;
      rpm_r       <= '0;
      deg_r       <= '0;
      revb_r      <= 1'b0;
      camsg_r     <= 1'b0;
      campos_r    <= '0;
      camev_r     <= 1'b0;
      ov_r        <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      // The divider starts as the sequencer enters one of its two divide steps.
      div_start_r <= (state_nxt != state_r) &&
                     (state_nxt == mtcd_pkg::ST_POSDIV || state_nxt == mtcd_pkg::ST_RPMDIV);
      if (state_r == mtcd_pkg::ST_OUT && (!ov_r || out_ch.ready))
        ov_r <= 1'b1;
      else if (out_ch.ready)
        ov_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          mtcd_pkg::CFG_TEETH: teeth_r <= cfg_wdata[7:0];
          mtcd_pkg::CFG_FLOOR: floor_r <= cfg_wdata;
          mtcd_pkg::CFG_CEIL:  ceil_r  <= cfg_wdata;
          mtcd_pkg::CFG_PHASE: phchk_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      case (state_r)
        mtcd_pkg::ST_EDGE: begin
          case (act_r)
            mtcd_pkg::ACT_CRANK: begin
              prev_r <= stamp_r;
              if (prev_r != '0 && stamp_r <= prev_r) begin
                valid_r <= 1'b0;
                acq_r   <= 1'b0;
              end else if (prev_r != '0) begin
                if (gap) begin
                  gapf_r  <= 1'b1;
                  pos_r   <= '0;
                  gapp_r  <= span;
                  phase_r <= camsg_r;
                  revb_r  <= camsg_r ? 1'b0 : ~revb_r;
                  camsg_r <= 1'b0;
                  div_a_r <= span;
                end else begin
                  gapf_r  <= 1'b0;
                  tp_r    <= span;
                  div_a_r <= 32'(pos_r) + 32'd1;
                  div_b_r <= 32'(teeth_r);
                  if (teeth_r == '0) pos_r <= '0;
                end
              end
            end
            mtcd_pkg::ACT_CAM: begin
              camsg_r  <= 1'b1;
              camev_r  <= 1'b1;
              campos_r <= pos_r;
            end
            mtcd_pkg::ACT_CLEAR: begin
              prev_r   <= '0;
              tp_r     <= '0;
              pos_r    <= '0;
              gapf_r   <= 1'b0;
              gapp_r   <= '0;
              phase_r  <= 1'b0;
              acq_r    <= 1'b0;
              valid_r  <= 1'b0;
              rpm_r    <= '0;
              deg_r    <= '0;
              revb_r   <= 1'b0;
              camsg_r  <= 1'b0;
              campos_r <= '0;
              camev_r  <= 1'b0;
            end
            default: ;
          endcase
        end
        mtcd_pkg::ST_TPDIV: begin
          tp_r <= 32'((64'(div_a_r) * 64'(mtcd_pkg::RECIP_3)) >> mtcd_pkg::RECIP_3_SH);
        end
        mtcd_pkg::ST_POSDIV: if (div_st.done) pos_r <= div_rem[7:0];
        mtcd_pkg::ST_MUL: begin
          rev_r       <= 32'(tp_r * 32'(positions));
          div_a_r     <= 32'(tp_r * 32'(positions)) + mtcd_pkg::DEG_ROUND;
        end
        mtcd_pkg::ST_DEGDIV: begin
          // Dividing by 360 is a shift by three and a divide by 45.
          deg_r   <= 32'((64'(div_a_r[31:3]) * 64'(mtcd_pkg::RECIP_45))
                         >> mtcd_pkg::RECIP_45_SH);
          div_a_r <= mtcd_pkg::US_PER_MIN;
          div_b_r <= rev_r;
        end
        mtcd_pkg::ST_RPMDIV: begin
          if (div_st.done) begin
            if (div_q < 32'(floor_r))     rpm_r <= '0;
            else if (div_q > 32'(ceil_r)) rpm_r <= ceil_r;
            else                          rpm_r <= div_q[15:0];
          end
        end
        mtcd_pkg::ST_FINAL: begin
          valid_r <= (rpm_r != '0);
          if (!phchk_r) phase_r <= 1'b1;
          if (rpm_r == '0)
            acq_r <= 1'b0;
          else if (gapf_r && (phase_r || !phchk_r))
            acq_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mtcd_pkg::ST_IDLE && in_ch.valid) begin
      act_r   <= in_ch.action;
      stamp_r <= in_ch.stamp_us;
    end
  end

  // The output beat is a snapshot, so the state can move on underneath it.
  always_ff @(posedge clk) begin
    if (state_r == mtcd_pkg::ST_OUT && (!ov_r || out_ch.ready)) begin
      out_ch.tooth_position  <= pos_r;
      out_ch.period_us       <= tp_r;
      out_ch.gap_seen        <= gapf_r;
      out_ch.gap_length_us   <= gapp_r;
      out_ch.phase_known     <= phase_r;
      out_ch.acquired        <= acq_r;
      out_ch.speed_valid     <= valid_r;
      out_ch.speed_rpm       <= rpm_r;
      out_ch.us_per_degree   <= deg_r;
      out_ch.revolution_half <= revb_r;
      out_ch.cam_tooth       <= campos_r;
      out_ch.cam_flag        <= camev_r;
    end
  end

  assign out_ch.valid = ov_r;

  a_acq_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    acq_r |-> valid_r) else $error("acquired without valid speed");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == mtcd_pkg::ST_POSDIV || state_r == mtcd_pkg::ST_RPMDIV))
    else $error("divider busy outside a divide step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == mtcd_pkg::ST_EDGE)
    else $error("accepted beat not taken up");
endmodule

FILE: verif/tb_missing_tooth_crank_decoder.sv
// ----------------------------------------------------------------------------
// tb_missing_tooth_crank_decoder: self-checking bench of the crank decoder
// Drives crank, cam, clear and spare events with random handshake gaps,
// predicts the decoder state after every event and compares each result beat.
// ----------------------------------------------------------------------------
module tb_missing_tooth_crank_decoder;

  typedef struct packed {
    logic [7:0]  tooth_position;
    logic [31:0] period_us;
    logic        gap_seen;
    logic [31:0] gap_length_us;
    logic        phase_known;
    logic        acquired;
    logic        speed_valid;
    logic [15:0] speed_rpm;
    logic [31:0] us_per_degree;
    logic        revolution_half;
    logic [7:0]  cam_tooth;
    logic        cam_flag;
  } status_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [mtcd_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 8'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mtcd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [mtcd_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  mtcd_in_if #(.STAMP_BITS(48)) in_ch ();
  mtcd_out_if out_ch ();

  missing_tooth_crank_decoder #(.STAMP_BITS(48)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted decoder registers.
  logic [7:0]  teeth;
  logic [15:0] floor_rpm, ceil_rpm;
  logic        phase_chk;
  logic [47:0] last_stamp;
  status_t     st;
  logic        cam_pending;

  status_t expected_status[$];
  int      errors = 0;
  int      cycles = 0;
  logic    hold_off = 1'b0;
  int      hold_cycles = 0;
  int      out_wait = 0;
  logic [47:0] now_us;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void clear_decoder();
    last_stamp = '0;
    st = '0;
    cam_pending = 1'b0;
  endfunction

  function automatic void predict_crank(input logic [47:0] stamp);
    logic [31:0] span, positions, rev_time, r;
    logic        gap;
    if (last_stamp == 0) begin
      last_stamp = stamp;
      return;
    end
    if (stamp <= last_stamp) begin
      last_stamp = stamp;
      st.speed_valid = 1'b0;
      st.acquired = 1'b0;
      return;
    end
    span = 32'(stamp - last_stamp);
    last_stamp = stamp;
    gap = (st.period_us > 0) && (span > (32'(st.period_us * 32'd3) / 32'd2));
    if (gap) begin
      st.gap_seen = 1'b1;
      st.tooth_position = '0;
      st.gap_length_us = span;
      if (cam_pending) begin
        st.phase_known = 1'b1;
        st.revolution_half = 1'b0;
      end else begin
        st.phase_known = 1'b0;
        st.revolution_half = ~st.revolution_half;
      end
      cam_pending = 1'b0;
      st.period_us = span / 32'd3;
    end else begin
      st.gap_seen = 1'b0;
      if (teeth > 0) st.tooth_position = 8'((32'(st.tooth_position) + 1) % teeth);
      else st.tooth_position = '0;
      st.period_us = span;
    end
    positions = 32'(teeth) + 32'd2;
    st.us_per_degree = 32'(st.period_us * positions + 32'd180) / 32'd360;
    if (!phase_chk) st.phase_known = 1'b1;
    if (st.gap_seen && st.phase_known) st.acquired = 1'b1;
    if (st.period_us > 0) begin
      rev_time = 32'(st.period_us * positions);
      if (rev_time > 0) begin
        r = 32'd60000000 / rev_time;
        if (r < floor_rpm) r = 0;
        else if (r > ceil_rpm) r = ceil_rpm;
        st.speed_rpm = r[15:0];
      end
    end
    st.speed_valid = st.speed_rpm > 0;
    if (!st.speed_valid) st.acquired = 1'b0;
  endfunction

  // Valid stays up between back-to-back beats and drops only for idle cycles.
  task automatic send_event(input logic [1:0] act, input logic [47:0] stamp);
    int idle;
    idle = $urandom_range(0, 16);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.stamp_us <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (act)
      mtcd_pkg::ACT_CRANK: predict_crank(stamp);
      mtcd_pkg::ACT_CAM: begin
        cam_pending = 1'b1;
        st.cam_flag = 1'b1;
        st.cam_tooth = st.tooth_position;
      end
      mtcd_pkg::ACT_CLEAR: clear_decoder();
      default: ;
    endcase
    expected_status.push_back(st);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_status.size() > 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mtcd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mtcd_pkg::CFG_TEETH: teeth = val[7:0];
      mtcd_pkg::CFG_FLOOR: floor_rpm = val;
      mtcd_pkg::CFG_CEIL:  ceil_rpm = val;
      mtcd_pkg::CFG_PHASE: phase_chk = val[0];
      default: ;
    endcase
  endtask

  // Sends a number of events with random speed, jitter, cam edges and noise.
  task automatic spin_wheel(input int beats, input int noise_pct);
    int unsigned per;
    int unsigned pos;
    per = $urandom_range(20, 3000);
    pos = 0;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(0, 4))
          0: send_event(mtcd_pkg::ACT_CLEAR, 48'({$urandom, $urandom}));
          1: send_event(mtcd_pkg::ACT_SPARE, 48'({$urandom, $urandom}));
          2: send_event(mtcd_pkg::ACT_CRANK, now_us - 48'($urandom_range(0, 50)));
          3: begin
            now_us += 48'({$urandom, $urandom} &
                          (64'hFFFF_FFFF_FFFF >> $urandom_range(0, 40)));
            send_event(mtcd_pkg::ACT_CRANK, now_us);
          end
          default: send_event(mtcd_pkg::ACT_CRANK, 48'd0);
        endcase
      end else if ($urandom_range(0, 30) == 0) begin
        send_event(mtcd_pkg::ACT_CAM, 48'({$urandom, $urandom}));
      end else begin
        now_us += 48'((pos == 0) ? per * 3 + $urandom_range(0, 4)
                                 : per + $urandom_range(0, 3) - 1);
        pos = (pos + 1) % (teeth + 1);
        send_event(mtcd_pkg::ACT_CRANK, now_us);
      end
    end
  endtask

  task automatic test_directed();
    send_event(mtcd_pkg::ACT_CRANK, 48'd1000);
    send_event(mtcd_pkg::ACT_CRANK, 48'd2000);
    send_event(mtcd_pkg::ACT_CRANK, 48'd3000);
    send_event(mtcd_pkg::ACT_CAM, 48'd0);
    send_event(mtcd_pkg::ACT_CRANK, 48'd6000);
    send_event(mtcd_pkg::ACT_CRANK, 48'd7000);
    send_event(mtcd_pkg::ACT_CRANK, 48'd7000);
    send_event(mtcd_pkg::ACT_CRANK, 48'd0);
    send_event(mtcd_pkg::ACT_CRANK, 48'hFFFF_FFFF_FFFE);
    send_event(mtcd_pkg::ACT_CRANK, 48'hFFFF_FFFF_FFFF);
    send_event(mtcd_pkg::ACT_SPARE, 48'h8000_0000_0001);
    send_event(mtcd_pkg::ACT_CLEAR, 48'd5);
    send_event(mtcd_pkg::ACT_CRANK, 48'd1);
    send_event(mtcd_pkg::ACT_CRANK, 48'h1_0000_0001);
    send_event(mtcd_pkg::ACT_CRANK, 48'h1_0000_0002);
    send_event(mtcd_pkg::ACT_CRANK, 48'hFFFF_0000_0000);
    send_event(mtcd_pkg::ACT_CLEAR, 48'd0);
    now_us = 48'd100;
  endtask

  task automatic test_config_sweep();
    write_reg(mtcd_pkg::CFG_TEETH, 16'd255);
    write_reg(mtcd_pkg::CFG_FLOOR, 16'd1);
    write_reg(mtcd_pkg::CFG_CEIL, 16'd65535);
    write_reg(mtcd_pkg::CFG_PHASE, 16'd0);
    spin_wheel(70, 10);
    write_reg(mtcd_pkg::CFG_TEETH, 16'd1);
    write_reg(mtcd_pkg::CFG_FLOOR, 16'd65535);
    write_reg(mtcd_pkg::CFG_CEIL, 16'd1);
    spin_wheel(50, 10);
    write_reg(mtcd_pkg::CFG_TEETH, 16'd0);
    write_reg(mtcd_pkg::CFG_FLOOR, 16'd300);
    write_reg(mtcd_pkg::CFG_CEIL, 16'd20000);
    write_reg(mtcd_pkg::CFG_PHASE, 16'd1);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    spin_wheel(40, 10);
    write_reg(mtcd_pkg::CFG_TEETH, 16'd58);
    write_reg(mtcd_pkg::CFG_FLOOR, 16'd500);
    write_reg(mtcd_pkg::CFG_CEIL, 16'd8000);
  endtask

  task automatic test_random_wheel();
    spin_wheel(300, 8);
  endtask

  // The receiver stops for a long stretch while beats keep coming.
  task automatic test_output_stall();
    hold_cycles = 600;
    hold_off = 1'b1;
    spin_wheel(12, 0);
    hold_off = 1'b0;
  endtask

  // After each accepted beat the receiver waits a random number of cycles.
  always @(negedge clk) begin
    if (hold_off && hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("missing_tooth_crank_decoder test failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_wait = $urandom_range(0, 16);
      got = '{out_ch.tooth_position, out_ch.period_us, out_ch.gap_seen, out_ch.gap_length_us,
              out_ch.phase_known, out_ch.acquired, out_ch.speed_valid, out_ch.speed_rpm,
              out_ch.us_per_degree, out_ch.revolution_half, out_ch.cam_tooth,
              out_ch.cam_flag};
      if (expected_status.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.tooth_position != want.tooth_position)
          report("tooth_position", got.tooth_position, want.tooth_position);
        if (got.period_us != want.period_us) report("period_us", got.period_us, want.period_us);
        if (got.gap_seen != want.gap_seen) report("gap_seen", got.gap_seen, want.gap_seen);
        if (got.gap_length_us != want.gap_length_us)
          report("gap_length_us", got.gap_length_us, want.gap_length_us);
        if (got.phase_known != want.phase_known)
          report("phase_known", got.phase_known, want.phase_known);
        if (got.acquired != want.acquired) report("acquired", got.acquired, want.acquired);
        if (got.speed_valid != want.speed_valid)
          report("speed_valid", got.speed_valid, want.speed_valid);
        if (got.speed_rpm != want.speed_rpm) report("speed_rpm", got.speed_rpm, want.speed_rpm);
        if (got.us_per_degree != want.us_per_degree)
          report("us_per_degree", got.us_per_degree, want.us_per_degree);
        if (got.revolution_half != want.revolution_half)
          report("revolution_half", got.revolution_half, want.revolution_half);
        if (got.cam_tooth != want.cam_tooth) report("cam_tooth", got.cam_tooth, want.cam_tooth);
        if (got.cam_flag != want.cam_flag) report("cam_flag", got.cam_flag, want.cam_flag);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = mtcd_pkg::ACT_CRANK;
    in_ch.stamp_us = '0;
    out_ch.ready = 1'b0;
    teeth = mtcd_pkg::TEETH_RST;
    floor_rpm = mtcd_pkg::FLOOR_RST;
    ceil_rpm = mtcd_pkg::CEIL_RST;
    phase_chk = 1'b1;
    now_us = 48'd100;
    clear_decoder();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_output_stall();
    test_config_sweep();
    test_random_wheel();
    drain();
    if (errors == 0) begin
      $display("missing_tooth_crank_decoder test passed");
    end else begin
      $display("missing_tooth_crank_decoder test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/mtcd_pkg.sv
rtl/mtcd_in_if.sv
rtl/mtcd_out_if.sv
rtl/mtcd_div.sv
rtl/missing_tooth_crank_decoder.sv
verif/tb_missing_tooth_crank_decoder.sv
